>>> rtl/svmrbf_pkg.sv
// Shared constants, codes and exponential tables for the SVM RBF classifier.
// No dependencies; imported by every module of the block.
package svmrbf_pkg;

   localparam int MAX_VECTORS_DEF = 64;
   localparam int FEATURES_DEF    = 5;
   localparam int IN_FEATURES     = 5;

   localparam int FEAT_W  = 16;
   localparam int COEF_W  = 18;
   localparam int BIAS_W  = 24;
   localparam int GAMMA_W = 16;
   localparam int ACTV_W  = 7;
   localparam int IDX_W   = 6;
   localparam int CSR_W   = 2;
   localparam int DEC_OUT_W = 32;
   localparam int MUL_W   = 18;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   localparam logic [CSR_W-1:0] CSR_BIAS   = 2'd0;
   localparam logic [CSR_W-1:0] CSR_GAMMA  = 2'd1;
   localparam logic [CSR_W-1:0] CSR_ACTIVE = 2'd2;

   localparam logic [GAMMA_W-1:0] GAMMA_RST = 16'd128;

   localparam longint unsigned EXP_STEP_Q32 = 64'd4278222805;

   typedef logic [16:0] frac_tab_type [256];

   function automatic frac_tab_type build_frac_tab();
      longint unsigned p;
      frac_tab_type    t;
      p = 64'd1 << 32;
      for (int f = 0; f < 256; f++) begin
         t[f] = 17'((p + 64'd32768) >> 16);
         p = (p * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
      end
      return t;
   endfunction

   localparam frac_tab_type EXP_FRAC_TAB = build_frac_tab();

   // exp(-i) in Q1.16 for integer part i; zero from 12 upwards
   function automatic logic [16:0] exp_int(input logic [7:0] i);
      logic [16:0] r;
      case (i)
         8'd0:    r = 17'd65536;
         8'd1:    r = 17'd24109;
         8'd2:    r = 17'd8869;
         8'd3:    r = 17'd3263;
         8'd4:    r = 17'd1200;
         8'd5:    r = 17'd442;
         8'd6:    r = 17'd162;
         8'd7:    r = 17'd60;
         8'd8:    r = 17'd22;
         8'd9:    r = 17'd8;
         8'd10:   r = 17'd3;
         8'd11:   r = 17'd1;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/svm_rbf_classifier_unit.sv
// SVM decision function with RBF kernel: sequencer, datapath and registers.
// Depends on svmrbf_pkg, svmrbf_mul and svmrbf_store.
//
// Request channel (req_*): valid/stall. A load item (operation 0) writes one
// support vector into slot entry_index and gives no result. A classify item
// (operation 1) gives one result item on the rsp_* channel (valid/stall)
// with the decision value and predicted class.
// Classification walks the active vectors on one shared 18x18 multiplier:
// per vector it sums the squared feature differences, scales the distance
// by gamma in NCH partial products (NCH = 3 at five features), then looks up
// the exponential and weights it by the vector's coefficient.
// req_stall is high while an item is being worked on.
// Results sit in an output register; a stalled result holds and the next
// item may be accepted and run until its own result is ready.
// CSR writes (csr_*) are always taken; write them only while idle.
// Reset clears the sequencer, the result valid and the registers to their
// defaults (bias 0, gamma 128, no active vectors). The stores are not
// cleared and must be loaded before use.
module svm_rbf_classifier_unit import svmrbf_pkg::*; #(
   parameter int MAX_VECTORS = MAX_VECTORS_DEF,
   parameter int FEATURES    = FEATURES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_operation,
   input  logic [IDX_W-1:0]        req_entry_index,
   input  logic signed [FEAT_W-1:0] req_feature_zero,
   input  logic signed [FEAT_W-1:0] req_feature_one,
   input  logic signed [FEAT_W-1:0] req_feature_two,
   input  logic signed [FEAT_W-1:0] req_feature_three,
   input  logic signed [FEAT_W-1:0] req_feature_four,
   input  logic signed [COEF_W-1:0] req_coefficient,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [DEC_OUT_W-1:0] rsp_decision_value,
   output logic                    rsp_predicted_class,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_W-1:0]        csr_index,
   input  logic [BIAS_W-1:0]       csr_data
);

   localparam int VEC_W  = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
   localparam int VCNT_W = $clog2(MAX_VECTORS + 1);
   localparam int FA_W   = (MAX_VECTORS * FEATURES > 1) ? $clog2(MAX_VECTORS * FEATURES) : 1;
   localparam int FIDX_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
   localparam int D2_W   = 32 + $clog2(FEATURES);
   localparam int PROD_W = D2_W + 16;
   localparam int NCH    = (D2_W + 16) / 17;
   localparam int CNT_W  = $clog2(((FEATURES > NCH) ? FEATURES : NCH) + 1);
   localparam int ACC_W  = (35 + VCNT_W > 48) ? 35 + VCNT_W : 48;
   localparam int DEC_W  = ACC_W - 14;
   localparam logic signed [DEC_W-1:0] DEC_MAX = DEC_W'(64'sd2147483647);
   localparam logic signed [DEC_W-1:0] DEC_MIN = DEC_W'(-64'sd2147483648);

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_DIST, ST_SCALE, ST_EXPO, ST_ROUND, ST_WEIGH, ST_ACCUM, ST_FINAL
   } state_type;

   state_type                  state_ff, state_in;
   logic signed [FEAT_W-1:0]   feat_ff [FEATURES];
   logic signed [FEAT_W-1:0]   feat_in [FEATURES];
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0]           tag_ff, tag_in;
   logic                       mvld_ff, mvld_in;
   logic [CNT_W-1:0]           mtag_ff, mtag_in;
   logic [FA_W-1:0]            waddr_ff, waddr_in;
   logic [FA_W-1:0]            raddr_ff, raddr_in;
   logic [VEC_W-1:0]           vec_ff, vec_in;
   logic [VCNT_W-1:0]          nvec_ff, nvec_in;
   logic [D2_W-1:0]            d2_ff, d2_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [15:0]                k_ff, k_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DEC_OUT_W-1:0] rsp_dec_ff, rsp_dec_in;
   logic                       rsp_class_ff, rsp_class_in;
   logic signed [BIAS_W-1:0]   bias_ff;
   logic [GAMMA_W-1:0]         gamma_ff;
   logic [ACTV_W-1:0]          active_ff;

   logic                       mul_en;
   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic signed [2*MUL_W-1:0]  mul_p;
   logic                       fs_we, fs_re, cs_we, cs_re;
   logic [FEAT_W-1:0]          fs_wdata, fs_rdata;
   logic [COEF_W-1:0]          cs_rdata;

   logic signed [FEAT_W-1:0]   in_feat [IN_FEATURES];
   logic [NCH*17-1:0]          d2_pad;
   logic [15:0]                x_q88;
   logic [33:0]                k_rnd;
   logic signed [ACC_W-1:0]    acc_rnd;
   logic signed [DEC_W-1:0]    dec_full;
   logic signed [DEC_W-1:0]    dec_sat;
   logic signed [FEAT_W:0]     diff;

   assign in_feat[0] = req_feature_zero;
   assign in_feat[1] = req_feature_one;
   assign in_feat[2] = req_feature_two;
   assign in_feat[3] = req_feature_three;
   assign in_feat[4] = req_feature_four;

   assign d2_pad  = (NCH*17)'(d2_ff);
   assign x_q88   = (|prod_ff[PROD_W-1:44]) ? 16'hffff : prod_ff[43:28];
   assign k_rnd   = {1'b0, mul_p[32:0]} + 34'd32768;
   assign acc_rnd = acc_ff + ACC_W'(32768);
   assign dec_full = DEC_W'($signed(acc_rnd[ACC_W-1:16])) - DEC_W'(bias_ff);
   assign dec_sat = (dec_full > DEC_MAX) ? DEC_MAX : ((dec_full < DEC_MIN) ? DEC_MIN : dec_full);
   assign diff    = (FEAT_W+1)'($signed(fs_rdata)) - (FEAT_W+1)'(feat_ff[tag_ff[FIDX_W-1:0]]);

   svmrbf_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   svmrbf_store #(
      .MAX_VECTORS (MAX_VECTORS),
      .FEATURES    (FEATURES)
   ) u_store (
      .clock    (clock),
      .fs_we    (fs_we),
      .fs_waddr (waddr_ff),
      .fs_wdata (fs_wdata),
      .fs_re    (fs_re),
      .fs_raddr (raddr_ff),
      .fs_rdata (fs_rdata),
      .cs_we    (cs_we),
      .cs_waddr (VEC_W'(req_entry_index)),
      .cs_wdata (req_coefficient),
      .cs_re    (cs_re),
      .cs_raddr (vec_ff),
      .cs_rdata (cs_rdata)
   );

   always_comb begin
      state_in = state_ff;
      feat_in  = feat_ff;
      cnt_in   = cnt_ff;
      rd_vld_in = rd_vld_ff;
      tag_in   = tag_ff;
      mvld_in  = mvld_ff;
      mtag_in  = mtag_ff;
      waddr_in = waddr_ff;
      raddr_in = raddr_ff;
      vec_in   = vec_ff;
      nvec_in  = nvec_ff;
      d2_in    = d2_ff;
      prod_in  = prod_ff;
      k_in     = k_ff;
      acc_in   = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_dec_in   = rsp_dec_ff;
      rsp_class_in = rsp_class_ff;
      mul_en   = 1'b0;
      mul_a    = '0;
      mul_b    = '0;
      fs_we    = 1'b0;
      fs_re    = 1'b0;
      cs_we    = 1'b0;
      cs_re    = 1'b0;
      fs_wdata = feat_ff[cnt_ff[FIDX_W-1:0]];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               for (int k = 0; k < FEATURES; k++) begin
                  feat_in[k] = (k < IN_FEATURES) ? in_feat[k] : '0;
               end
               if (req_operation == OP_LOAD) begin
                  if (32'(req_entry_index) < MAX_VECTORS) begin
                     cs_we    = 1'b1;
                     waddr_in = FA_W'(32'(req_entry_index) * FEATURES);
                     cnt_in   = '0;
                     state_in = ST_LOAD;
                  end
               end else begin
                  nvec_in  = (32'(active_ff) > MAX_VECTORS) ? VCNT_W'(MAX_VECTORS)
                                                            : VCNT_W'(active_ff);
                  raddr_in = '0;
                  vec_in   = '0;
                  acc_in   = '0;
                  d2_in    = '0;
                  prod_in  = '0;
                  cnt_in   = '0;
                  rd_vld_in = 1'b0;
                  mvld_in  = 1'b0;
                  state_in = (active_ff == '0) ? ST_FINAL : ST_DIST;
               end
            end
         end
         ST_LOAD: begin
            fs_we    = 1'b1;
            waddr_in = waddr_ff + FA_W'(1);
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FEATURES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIST: begin
            if (cnt_ff == '0) begin
               cs_re = 1'b1;
            end
            if (cnt_ff < CNT_W'(FEATURES)) begin
               fs_re     = 1'b1;
               raddr_in  = raddr_ff + FA_W'(1);
               rd_vld_in = 1'b1;
               tag_in    = cnt_ff;
               cnt_in    = cnt_ff + CNT_W'(1);
            end else begin
               rd_vld_in = 1'b0;
            end
            if (rd_vld_ff) begin
               mul_en  = 1'b1;
               mul_a   = MUL_W'(diff);
               mul_b   = MUL_W'(diff);
               mvld_in = 1'b1;
            end else begin
               mvld_in = 1'b0;
            end
            if (mvld_ff) begin
               d2_in = d2_ff + D2_W'(mul_p[31:0]);
            end
            if (cnt_ff == CNT_W'(FEATURES) && !rd_vld_ff && !mvld_ff) begin
               cnt_in   = '0;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (cnt_ff < CNT_W'(NCH)) begin
               mul_en  = 1'b1;
               mul_a   = MUL_W'(d2_pad[17*cnt_ff +: 17]);
               mul_b   = MUL_W'(gamma_ff);
               mvld_in = 1'b1;
               mtag_in = cnt_ff;
               cnt_in  = cnt_ff + CNT_W'(1);
            end else begin
               mvld_in = 1'b0;
            end
            if (mvld_ff) begin
               prod_in = prod_ff + (PROD_W'(mul_p[33:0]) << (17 * mtag_ff));
            end
            if (cnt_ff == CNT_W'(NCH) && !mvld_ff) begin
               state_in = ST_EXPO;
            end
         end
         ST_EXPO: begin
            mul_en   = 1'b1;
            mul_a    = MUL_W'(exp_int(x_q88[15:8]));
            mul_b    = MUL_W'(EXP_FRAC_TAB[x_q88[7:0]]);
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            k_in     = (|k_rnd[33:32]) ? 16'hffff : k_rnd[31:16];
            state_in = ST_WEIGH;
         end
         ST_WEIGH: begin
            mul_en   = 1'b1;
            mul_a    = cs_rdata;
            mul_b    = MUL_W'(k_ff);
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            acc_in = acc_ff + ACC_W'(mul_p);
            if ((VCNT_W'(vec_ff) + VCNT_W'(1)) == nvec_ff) begin
               state_in = ST_FINAL;
            end else begin
               vec_in   = vec_ff + VEC_W'(1);
               cnt_in   = '0;
               d2_in    = '0;
               prod_in  = '0;
               state_in = ST_DIST;
            end
         end
         ST_FINAL: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_dec_in   = DEC_OUT_W'(dec_sat);
               rsp_class_in = !dec_sat[DEC_W-1] && (dec_sat != '0);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         mvld_ff      <= 1'b0;
         bias_ff      <= '0;
         gamma_ff     <= GAMMA_RST;
         active_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         mvld_ff      <= mvld_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_BIAS:   bias_ff   <= csr_data;
               CSR_GAMMA:  gamma_ff  <= csr_data[GAMMA_W-1:0];
               CSR_ACTIVE: active_ff <= csr_data[ACTV_W-1:0];
               default:    ;
            endcase
         end
      end
      feat_ff    <= feat_in;
      cnt_ff     <= cnt_in;
      tag_ff     <= tag_in;
      mtag_ff    <= mtag_in;
      waddr_ff   <= waddr_in;
      raddr_ff   <= raddr_in;
      vec_ff     <= vec_in;
      nvec_ff    <= nvec_in;
      d2_ff      <= d2_in;
      prod_ff    <= prod_in;
      k_ff       <= k_in;
      acc_ff     <= acc_in;
      rsp_dec_ff <= rsp_dec_in;
      rsp_class_ff <= rsp_class_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_decision_value  = rsp_dec_ff;
   assign rsp_predicted_class = rsp_class_ff;

   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINAL))
      else $error("result raised outside final step");

   a_class_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_class_ff) |-> (!rsp_dec_ff[DEC_OUT_W-1] && rsp_dec_ff != '0))
      else $error("class disagrees with decision sign");

   a_load_no_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD || state_ff == ST_IDLE) |-> !mul_en)
      else $error("multiplier used outside classification");

   a_dist_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE && $past(state_ff == ST_DIST)) |-> $past(!rd_vld_ff && !mvld_ff))
      else $error("distance pipeline left before draining");

endmodule

>>> rtl/svmrbf_mul.sv
// Shared signed 18x18 multiplier with registered product.
// Depends on svmrbf_pkg.
module svmrbf_mul import svmrbf_pkg::*; (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [MUL_W-1:0]   a,
   input  logic signed [MUL_W-1:0]   b,
   output logic signed [2*MUL_W-1:0] p
);

   logic signed [2*MUL_W-1:0] p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= a * b;
      end
   end

   assign p = p_ff;

endmodule

>>> rtl/svmrbf_store.sv
// Support vector feature and coefficient memories, registered reads.
// Depends on svmrbf_pkg.
module svmrbf_store import svmrbf_pkg::*; #(
   parameter int MAX_VECTORS = MAX_VECTORS_DEF,
   parameter int FEATURES    = FEATURES_DEF,
   localparam int VEC_W = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1,
   localparam int FA_W  = (MAX_VECTORS * FEATURES > 1) ? $clog2(MAX_VECTORS * FEATURES) : 1
) (
   input  logic              clock,
   input  logic              fs_we,
   input  logic [FA_W-1:0]   fs_waddr,
   input  logic [FEAT_W-1:0] fs_wdata,
   input  logic              fs_re,
   input  logic [FA_W-1:0]   fs_raddr,
   output logic [FEAT_W-1:0] fs_rdata,
   input  logic              cs_we,
   input  logic [VEC_W-1:0]  cs_waddr,
   input  logic [COEF_W-1:0] cs_wdata,
   input  logic              cs_re,
   input  logic [VEC_W-1:0]  cs_raddr,
   output logic [COEF_W-1:0] cs_rdata
);

   logic [FEAT_W-1:0] feat_mem [MAX_VECTORS*FEATURES];
   logic [COEF_W-1:0] coef_mem [MAX_VECTORS];
   logic [FEAT_W-1:0] fs_rdata_ff;
   logic [COEF_W-1:0] cs_rdata_ff;

   always_ff @(posedge clock) begin
      if (fs_we) begin
         feat_mem[fs_waddr] <= fs_wdata;
      end
      if (fs_re) begin
         fs_rdata_ff <= feat_mem[fs_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cs_we) begin
         coef_mem[cs_waddr] <= cs_wdata;
      end
      if (cs_re) begin
         cs_rdata_ff <= coef_mem[cs_raddr];
      end
   end

   assign fs_rdata = fs_rdata_ff;
   assign cs_rdata = cs_rdata_ff;

endmodule
